// ===== hw/rtl/frb_pkg.sv =====
// package for the fragment reassembly buffer
// types, constants and status codes; no dependencies
`default_nettype none
package frb_pkg;
   localparam int SLOTS = 4;
   localparam int MAX_PIECES = 16;
   localparam int PIECE_BYTES = 8;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int IDX_W = $clog2(MAX_PIECES);
   localparam int ADDR_W = SLOT_W + IDX_W;

   typedef enum logic [2:0] {
      ST_STORED = 3'd0, ST_MISMATCH = 3'd1, ST_RANGE = 3'd2,
      ST_DUP = 3'd3, ST_STALE = 3'd4, ST_DONE = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE, FSM_DECIDE, FSM_EMIT, FSM_LAST
   } fsm_type;

   typedef struct packed {
      logic [31:0] frame_sequence;
      logic [4:0]  piece_count;
      logic [3:0]  piece_index;
      logic [63:0] payload;
      logic [3:0]  payload_bytes;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] piece_data;
      logic [3:0]  piece_len;
      logic        last_piece;
      logic [31:0] mismatched_total;
      logic [31:0] duplicate_total;
      logic [31:0] abandoned_total;
      logic [31:0] completed_total;
   } rsp_type;

   function automatic logic [63:0] mask_bytes(input logic [63:0] v, input logic [3:0] len);
      logic [63:0] m;
      m = '0;
      for (int b = 0; b < 8; b++)
         if (4'(b) < len) m[b*8 +: 8] = 8'hff;
      return v & m;
   endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/frb_piece_ram.sv =====
// piece store: data and length per slot and index
// synchronous write, registered read; uses frb_pkg
`default_nettype none
module frb_piece_ram import frb_pkg::*; (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [67:0]       wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic [67:0]            rd_data
);
   logic [67:0] mem [SLOTS*MAX_PIECES];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/fragment_reassembly_buffer.sv =====
// fragment reassembly buffer top level
// slot table in registers, pieces in frb_piece_ram; uses frb_pkg
//
// channel  direction  ports         transfer
// req      in         req_*         start high and busy low
// rsp      out        rsp_*         rsp_strobe high for one cycle
//
// a fragment that does not complete a frame is decided, then answered
// a completing fragment is answered with one ram read per piece
// reset clears the slot table and counters at once; the ram needs no clear
// the receiver cannot stall; busy holds off requests while a fragment is at work
`default_nettype none
module fragment_reassembly_buffer import frb_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  req_type   req_item,
   output logic      busy,
   output logic      rsp_strobe,
   output rsp_type   rsp_item
);
   fsm_type state_ff, state_in;
   req_type req_ff;
   logic [SLOTS-1:0] use_ff;
   logic [31:0] seq_ff [SLOTS];
   logic [4:0]  cnt_ff [SLOTS];
   logic [4:0]  have_ff [SLOTS];
   logic [15:0] mask_ff [SLOTS];
   logic [31:0] ev_ff [4];
   logic [SLOT_W-1:0] slot_ff;
   logic [4:0] k_ff, n_ff;
   logic [31:0] done_seq_ff;
   logic [2:0] st_ff;
   logic strobe_ff;
   logic [67:0] rd_data;

   // decision logic on the latched fragment
   logic [3:0] len_sat;
   logic hit, has_free, stale, cmis, over, range_err, dup, complete;
   logic [SLOT_W-1:0] hit_s, free_s, old_s, s;
   logic [4:0] cnt_s;
   logic [15:0] mask_s;
   logic [4:0] have_s;
   logic [2:0] aband;

   always_comb begin
      len_sat = (req_ff.payload_bytes > 4'(PIECE_BYTES)) ? 4'(PIECE_BYTES)
                                                        : req_ff.payload_bytes;
      over = req_ff.piece_count > 5'(MAX_PIECES);
      hit = 1'b0; hit_s = '0; has_free = 1'b0; free_s = '0; old_s = '0;
      for (int i = SLOTS-1; i >= 0; i--) begin
         if (use_ff[i] && seq_ff[i] == req_ff.frame_sequence) begin
            hit = 1'b1; hit_s = SLOT_W'(i);
         end
         if (!use_ff[i]) begin
            has_free = 1'b1; free_s = SLOT_W'(i);
         end
      end
      for (int i = 1; i < SLOTS; i++)
         if (seq_ff[i] < seq_ff[old_s]) old_s = SLOT_W'(i);
      stale = !hit && !has_free && seq_ff[old_s] > req_ff.frame_sequence;
      s = hit ? hit_s : (has_free ? free_s : old_s);
      cmis = hit && cnt_ff[hit_s] != req_ff.piece_count;
      cnt_s = req_ff.piece_count;
      mask_s = hit ? mask_ff[s] : 16'h0;
      have_s = hit ? have_ff[s] : 5'd0;
      range_err = {1'b0, req_ff.piece_index} >= cnt_s;
      dup = mask_s[req_ff.piece_index];
      complete = have_s + 5'd1 >= cnt_s;
      aband = '0;
      for (int i = 0; i < SLOTS; i++)
         if (use_ff[i] && seq_ff[i] < req_ff.frame_sequence && have_ff[i] != 5'd0
             && !(!hit && !has_free && SLOT_W'(i) == s))
            aband = aband + 3'd1;
   end

   logic store_go;
   assign store_go = state_ff == FSM_DECIDE && !over && !stale && !cmis
                     && !range_err && !dup;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE:   if (start) state_in = FSM_DECIDE;
         FSM_DECIDE: state_in = (store_go && complete) ? FSM_EMIT : FSM_IDLE;
         FSM_EMIT:   if (k_ff == n_ff) state_in = FSM_LAST;
         FSM_LAST:   state_in = FSM_IDLE;
         default:    state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      busy = state_ff != FSM_IDLE;
   end

   logic [ADDR_W-1:0] rd_addr;
   assign rd_addr = {slot_ff, k_ff[IDX_W-1:0]};

   frb_piece_ram u_ram (
      .clock   (clock),
      .wr_en   (store_go),
      .wr_addr ({s, req_ff.piece_index[IDX_W-1:0]}),
      .wr_data ({len_sat, mask_bytes(req_ff.payload, len_sat)}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   logic emit_ff, emit_last_ff;

   always_ff @(posedge clock) begin
      if (start && !busy) req_ff <= req_item;
      if (reset) begin
         state_ff <= FSM_IDLE;
         use_ff <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            seq_ff[i] <= '0; cnt_ff[i] <= '0; have_ff[i] <= '0; mask_ff[i] <= '0;
         end
         for (int i = 0; i < 4; i++) ev_ff[i] <= '0;
         strobe_ff <= 1'b0; emit_ff <= 1'b0; emit_last_ff <= 1'b0;
         k_ff <= '0; n_ff <= '0; slot_ff <= '0; st_ff <= ST_STORED;
         done_seq_ff <= '0;
      end else begin
         state_ff <= state_in;
         strobe_ff <= 1'b0;
         emit_ff <= 1'b0;
         emit_last_ff <= 1'b0;
         if (state_ff == FSM_DECIDE) begin
            if (over || cmis) begin
               ev_ff[0] <= ev_ff[0] + 32'd1; st_ff <= ST_MISMATCH; strobe_ff <= 1'b1;
            end else if (stale) begin
               ev_ff[2] <= ev_ff[2] + 32'd1; st_ff <= ST_STALE; strobe_ff <= 1'b1;
            end else begin
               if (!hit) begin
                  use_ff[s] <= 1'b1; seq_ff[s] <= req_ff.frame_sequence;
                  cnt_ff[s] <= cnt_s;
               end
               ev_ff[2] <= ev_ff[2] + 32'(!hit && !has_free)
                           + ((!range_err && !dup && complete) ? 32'(aband) : 32'd0);
               if (range_err) begin
                  if (!hit) begin
                     have_ff[s] <= '0; mask_ff[s] <= '0;
                  end
                  ev_ff[0] <= ev_ff[0] + 32'd1; st_ff <= ST_RANGE; strobe_ff <= 1'b1;
               end else if (dup) begin
                  ev_ff[1] <= ev_ff[1] + 32'd1; st_ff <= ST_DUP; strobe_ff <= 1'b1;
               end else begin
                  mask_ff[s] <= mask_s | (16'h1 << req_ff.piece_index);
                  have_ff[s] <= have_s + 5'd1;
                  if (!complete) begin
                     st_ff <= ST_STORED; strobe_ff <= 1'b1;
                  end else begin
                     ev_ff[3] <= ev_ff[3] + 32'd1;
                     slot_ff <= s; k_ff <= '0; n_ff <= cnt_s - 5'd1;
                     done_seq_ff <= req_ff.frame_sequence;
                  end
               end
            end
         end
         if (state_ff == FSM_EMIT) begin
            emit_ff <= 1'b1;
            emit_last_ff <= k_ff == n_ff;
            k_ff <= k_ff + 5'd1;
            if (k_ff == n_ff)
               for (int i = 0; i < SLOTS; i++)
                  if (use_ff[i] && seq_ff[i] <= done_seq_ff) begin
                     use_ff[i] <= 1'b0; seq_ff[i] <= '0; cnt_ff[i] <= '0;
                     have_ff[i] <= '0; mask_ff[i] <= '0;
                  end
         end
      end
   end

   always_comb begin
      rsp_strobe = strobe_ff || emit_ff;
      rsp_item.status = emit_ff ? 3'(ST_DONE) : st_ff;
      rsp_item.piece_data = emit_ff ? mask_bytes(rd_data[63:0], rd_data[67:64]) : 64'h0;
      rsp_item.piece_len = emit_ff ? rd_data[67:64] : 4'h0;
      rsp_item.last_piece = emit_ff && emit_last_ff;
      rsp_item.mismatched_total = ev_ff[0];
      rsp_item.duplicate_total = ev_ff[1];
      rsp_item.abandoned_total = ev_ff[2];
      rsp_item.completed_total = ev_ff[3];
   end
endmodule
`default_nettype wire

// ===== tb/fragment_reassembly_buffer_tb.sv =====
// testbench for the fragment reassembly buffer: random and directed fragments
// checked against a behavioral predictor in a small scoreboard class; uses frb_pkg
`timescale 1ns / 100ps
module fragment_reassembly_buffer_tb import frb_pkg::*; ();

   class reassembly_scoreboard;
      bit          in_use [SLOTS];
      logic [31:0] seq_of [SLOTS];
      logic [4:0]  count_of [SLOTS];
      logic [4:0]  have_of [SLOTS];
      logic [15:0] arrived [SLOTS];
      logic [63:0] piece_data [SLOTS*MAX_PIECES];
      logic [3:0]  piece_len [SLOTS*MAX_PIECES];
      logic [31:0] n_mismatch, n_dup, n_abandon, n_done;
      rsp_type     pending [$];
      int          mismatches;

      function void clear();
         for (int i = 0; i < SLOTS; i++) begin
            in_use[i] = 0; seq_of[i] = 0; count_of[i] = 0; have_of[i] = 0; arrived[i] = 0;
         end
         n_mismatch = 0; n_dup = 0; n_abandon = 0; n_done = 0;
         pending.delete();
         mismatches = 0;
      endfunction

      function void push(status_type st, logic [63:0] d, logic [3:0] l, logic lst);
         rsp_type r;
         r.status = st; r.piece_data = d; r.piece_len = l; r.last_piece = lst;
         r.mismatched_total = n_mismatch; r.duplicate_total = n_dup;
         r.abandoned_total = n_abandon; r.completed_total = n_done;
         pending.insert(pending.size(), r);
      endfunction

      function void note_fragment(req_type q);
         logic [3:0]  len;
         logic [63:0] d, m;
         int s, old;
         len = (q.payload_bytes > PIECE_BYTES) ? 4'(PIECE_BYTES) : q.payload_bytes;
         m = '0;
         for (int b = 0; b < 8; b++) if (b < len) m[b*8 +: 8] = 8'hff;
         d = q.payload & m;
         if (q.piece_count > MAX_PIECES) begin
            n_mismatch++; push(ST_MISMATCH, 0, 0, 0); return;
         end
         s = -1;
         for (int i = 0; i < SLOTS; i++)
            if (s < 0 && in_use[i] && seq_of[i] == q.frame_sequence) s = i;
         if (s >= 0) begin
            if (count_of[s] != q.piece_count) begin
               n_mismatch++; push(ST_MISMATCH, 0, 0, 0); return;
            end
         end else begin
            for (int i = 0; i < SLOTS; i++) if (s < 0 && !in_use[i]) s = i;
            if (s < 0) begin
               old = 0;
               for (int i = 1; i < SLOTS; i++) if (seq_of[i] < seq_of[old]) old = i;
               n_abandon++;
               if (seq_of[old] > q.frame_sequence) begin
                  push(ST_STALE, 0, 0, 0); return;
               end
               s = old;
            end
            in_use[s] = 1; seq_of[s] = q.frame_sequence; count_of[s] = q.piece_count;
            have_of[s] = 0; arrived[s] = 0;
         end
         if (q.piece_index >= count_of[s]) begin
            n_mismatch++; push(ST_RANGE, 0, 0, 0); return;
         end
         if (arrived[s][q.piece_index]) begin
            n_dup++; push(ST_DUP, 0, 0, 0); return;
         end
         piece_data[s*MAX_PIECES + q.piece_index] = d;
         piece_len[s*MAX_PIECES + q.piece_index] = len;
         arrived[s][q.piece_index] = 1;
         have_of[s]++;
         if (have_of[s] < count_of[s]) begin
            push(ST_STORED, 0, 0, 0); return;
         end
         n_done++;
         for (int i = 0; i < SLOTS; i++)
            if (in_use[i] && seq_of[i] < q.frame_sequence && have_of[i] > 0) n_abandon++;
         for (int k = 0; k < count_of[s]; k++)
            push(ST_DONE, piece_data[s*MAX_PIECES + k], piece_len[s*MAX_PIECES + k],
                 k == count_of[s] - 1);
         for (int i = 0; i < SLOTS; i++)
            if (in_use[i] && seq_of[i] <= q.frame_sequence) begin
               in_use[i] = 0; seq_of[i] = 0; count_of[i] = 0; have_of[i] = 0; arrived[i] = 0;
            end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
         end
      endfunction
   endclass

   logic    clock = 0, reset = 1, start = 0;
   req_type req_item = '0;
   logic    busy, rsp_strobe;
   rsp_type rsp_item;
   reassembly_scoreboard frames = new();
   int      idle_cycles = 0;
   int      sent = 0;
   logic [31:0] base_seq;

   fragment_reassembly_buffer dut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      if (reset) idle_cycles <= 0;
      else begin
         if (rsp_strobe) frames.check_result(rsp_item);
         if (start && !busy) frames.note_fragment(req_item);
         if (rsp_strobe || (start && !busy)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 2000) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   task automatic send_fragment(logic [31:0] sq, logic [4:0] cnt, logic [3:0] ix,
                                logic [63:0] pl, logic [3:0] nb);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 2);
      if ($urandom_range(0, 3) == 0) gap = 1;
      repeat (gap) @(negedge clock);
      req_item <= '{sq, cnt, ix, pl, nb};
      start <= 1;
      do @(posedge clock); while (busy);
      sent++;
      @(negedge clock);
      start <= 0;
   endtask

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   task automatic send_frame(logic [31:0] sq, int cnt, bit drop_one);
      int order [$];
      for (int i = 0; i < cnt; i++) order.insert(order.size(), i);
      order.shuffle();
      if (drop_one && cnt > 1) void'(order.pop_back());
      foreach (order[i])
         send_fragment(sq, 5'(cnt), 4'(order[i]), rand_word(), 4'($urandom_range(0, 15)));
   endtask

   initial begin
      frames.clear();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed cases
      send_fragment(32'd5, 5'd17, 4'd0, '1, 4'd8);
      send_fragment(32'd5, 5'd31, 4'd15, '1, 4'd15);
      send_fragment(32'd5, 5'd0, 4'd0, '1, 4'd8);
      send_fragment(32'd6, 5'd2, 4'd3, '1, 4'd8);
      send_fragment(32'd6, 5'd2, 4'd0, 64'hffff_ffff_ffff_ffff, 4'd15);
      send_fragment(32'd6, 5'd2, 4'd0, 64'h1234, 4'd2);
      send_fragment(32'd6, 5'd3, 4'd1, 64'h1234, 4'd2);
      send_fragment(32'd6, 5'd2, 4'd1, 64'h0123_4567_89ab_cdef, 4'd0);
      send_frame(32'hffff_ffff, 16, 1);
      send_fragment(32'd10, 5'd2, 4'd0, rand_word(), 4'd3);
      send_fragment(32'd11, 5'd2, 4'd0, rand_word(), 4'd8);
      send_fragment(32'd12, 5'd2, 4'd0, rand_word(), 4'd1);
      send_fragment(32'd2, 5'd2, 4'd0, rand_word(), 4'd4);
      send_fragment(32'd13, 5'd2, 4'd0, rand_word(), 4'd5);
      send_fragment(32'd12, 5'd2, 4'd1, rand_word(), 4'd7);
      send_frame(32'hffff_ffff, 16, 0);
      send_frame(32'd0, 1, 0);
      // random traffic, mostly well-formed frames around a moving sequence
      base_seq = $urandom;
      while (sent < 410) begin
         case ($urandom_range(0, 9))
            0: send_fragment($urandom, 5'($urandom), 4'($urandom), rand_word(),
                             4'($urandom));
            1, 2: send_frame(base_seq + $urandom_range(0, 6), $urandom_range(1, 16), 1);
            default: send_frame(base_seq + $urandom_range(0, 6),
                                ($urandom_range(0, 7) == 0) ? 16 : $urandom_range(1, 5), 0);
         endcase
         base_seq = base_seq + $urandom_range(0, 3);
      end
      while (frames.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (frames.mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
